/* sv/olie_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// olie_pkg
// Shared types and constants of the ordered list insert engine.
// ----------------------------------------------------------------------------
package olie_pkg;

   localparam int DefCapacity = 64;
   localparam int ValueWidth  = 32;
   localparam int PosWidth    = 8;

   typedef enum logic [1:0] {
      KIND_HEAD = 2'd0,
      KIND_TAIL = 2'd1,
      KIND_POS  = 2'd2,
      KIND_DUMP = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_EMPTY      = 3'd1,
      STAT_NOPOS      = 3'd2,
      STAT_FULL       = 3'd3,
      STAT_DUMP_EMPTY = 3'd4
   } status_type;

   typedef struct packed {
      kind_type                      kind;
      logic signed [ValueWidth-1:0]  value;
      logic [PosWidth-1:0]           position;
   } req_type;

   typedef struct packed {
      status_type                    status;
      logic signed [ValueWidth-1:0]  element;
      logic                          last;
   } rsp_type;

   // Outcome of decoding one request against the current list length.
   typedef struct packed {
      logic       is_dump;
      logic       direct;   // insert lands at the end, nothing to move
      status_type status;
   } dec_type;

endpackage
`default_nettype wire

/* sv/olie_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// olie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module olie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* sv/olie_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// olie_decode
// Works out the insert index and the status of one request from its kind,
// its position and the current list length.
// ----------------------------------------------------------------------------
module olie_decode
   import olie_pkg::*;
#(
   parameter int CAPACITY = DefCapacity
) (
   input  wire req_type                          req,
   input  wire logic [$clog2(CAPACITY+1)-1:0]    length,
   output dec_type                               dec,
   output logic      [$clog2(CAPACITY+1)-1:0]    idx
);

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > PosWidth) ? LW : PosWidth) + 1;

   logic [CW-1:0] pos_wide;
   logic [CW-1:0] len_plus1;
   logic          pos_err;

   always_comb begin
      pos_wide  = CW'(req.position);
      len_plus1 = CW'(length) + CW'(1);
      pos_err   = 1'b0;
      idx       = '0;
      dec.is_dump = 1'b0;
      dec.status  = STAT_OK;

      unique case (req.kind)
         KIND_HEAD: idx = '0;
         KIND_TAIL: idx = length;
         KIND_POS: begin
            if (req.position == PosWidth'(1)) begin
               idx = '0;
            end else if (length == '0) begin
               pos_err    = 1'b1;
               dec.status = STAT_EMPTY;
            end else if (req.position == '0 || pos_wide > len_plus1) begin
               pos_err    = 1'b1;
               dec.status = STAT_NOPOS;
            end else begin
               idx = LW'(pos_wide - CW'(1));
            end
         end
         KIND_DUMP: begin
            dec.is_dump = 1'b1;
            dec.status  = (length == '0) ? STAT_DUMP_EMPTY : STAT_OK;
         end
         default: idx = '0;
      endcase

      // Position errors win over the full flag.
      if (!dec.is_dump && !pos_err && length == LW'(CAPACITY)) begin
         dec.status = STAT_FULL;
      end

      dec.direct = (idx == length);
   end

endmodule
`default_nettype wire

/* sv/ordered_list_insert_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_insert_engine
// Ordered list of signed values held in a RAM; inserts move the tail of the
// list one entry per cycle, dumps stream the list out from the head.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_ready   req_data (kind, value, position)
//  rsp      out        rsp_valid/rsp_ready   rsp_data (status, element, last)
//
//  An error, an empty dump or an insert at the end of the list registers its
//  answer as the request is taken. An insert at index i into a list of
//  length n moves entries i to n-1 up by one, one RAM read and write pair
//  for each entry moved. A dump of n entries takes one RAM read per element.
//  Requests are taken only when idle and the output register is free; a
//  stall on rsp holds the final write and the dump. Reset empties the list.
// ----------------------------------------------------------------------------
module ordered_list_insert_engine
   import olie_pkg::*;
#(
   parameter int CAPACITY = DefCapacity
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_FINAL,
      S_WRITE,
      S_DUMP
   } state_type;

   state_type         state_ff, state_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic              pend_ff, pend_in;
   logic              rdv_ff, rdv_in;
   logic              rd_last_ff, rd_last_in;
   logic              issued_ff, issued_in;
   logic signed [ValueWidth-1:0] val_ff, val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   dec_type           dec;
   logic [LW-1:0]     dec_idx;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [ValueWidth-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [ValueWidth-1:0] ram_rdata;

   logic              out_free;
   logic              accept;
   logic              load_out;
   logic              ptr_is_last;

   olie_decode #(.CAPACITY(CAPACITY)) u_decode (
      .req    (req_data),
      .length (len_ff),
      .dec    (dec),
      .idx    (dec_idx)
   );

   olie_ram #(.WIDTH(ValueWidth), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE) && out_free;
   assign accept      = req_valid && req_ready;
   assign load_out    = rdv_ff && out_free;
   assign ptr_is_last = (LW'(ptr_ff) == len_ff - LW'(1));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      pend_addr_in = pend_addr_ff;
      pend_in      = pend_ff;
      rdv_in       = rdv_ff;
      rd_last_in   = rd_last_ff;
      issued_in    = issued_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = val_ff;
      ram_re    = 1'b0;
      ram_raddr = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in = req_data.value;
               idx_in = AW'(dec_idx);
               if (dec.status != STAT_OK) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = dec.status;
                  rsp_in.element = '0;
                  rsp_in.last    = 1'b1;
               end else if (dec.is_dump) begin
                  ptr_in    = '0;
                  rdv_in    = 1'b0;
                  issued_in = 1'b0;
                  state_in  = S_DUMP;
               end else if (dec.direct) begin
                  // Nothing to move: write and answer straight away.
                  ram_we         = 1'b1;
                  ram_waddr      = AW'(dec_idx);
                  ram_wdata      = req_data.value;
                  len_in         = len_ff + LW'(1);
                  rsp_valid_in   = 1'b1;
                  rsp_in.status  = STAT_OK;
                  rsp_in.element = req_data.value;
                  rsp_in.last    = 1'b1;
               end else begin
                  ptr_in   = AW'(len_ff - LW'(1));
                  pend_in  = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // Read entry ptr while writing the entry read last cycle one up.
            ram_re       = 1'b1;
            ram_raddr    = ptr_ff;
            ram_we       = pend_ff;
            ram_waddr    = pend_addr_ff;
            ram_wdata    = ram_rdata;
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff + AW'(1);
            if (ptr_ff == idx_ff) begin
               state_in = S_FINAL;
            end else begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         S_FINAL: begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_ff;
            ram_wdata = ram_rdata;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            if (out_free) begin
               ram_we         = 1'b1;
               ram_waddr      = idx_ff;
               ram_wdata      = val_ff;
               len_in         = len_ff + LW'(1);
               rsp_valid_in   = 1'b1;
               rsp_in.status  = STAT_OK;
               rsp_in.element = val_ff;
               rsp_in.last    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_DUMP: begin
            if (load_out) begin
               rsp_valid_in   = 1'b1;
               rsp_in.status  = STAT_OK;
               rsp_in.element = $signed(ram_rdata);
               rsp_in.last    = rd_last_ff;
               rdv_in         = 1'b0;
               if (rd_last_ff) begin
                  state_in = S_IDLE;
               end
            end
            // The read data register holds its word until the next read, so a
            // new read is only issued once the held word has moved on.
            if (!issued_ff && (!rdv_ff || load_out)) begin
               ram_re     = 1'b1;
               ram_raddr  = ptr_ff;
               rdv_in     = 1'b1;
               rd_last_in = ptr_is_last;
               issued_in  = ptr_is_last;
               ptr_in     = ptr_ff + AW'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         pend_ff      <= 1'b0;
         rdv_ff       <= 1'b0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pend_ff      <= pend_in;
         rdv_ff       <= rdv_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff       <= ptr_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      rd_last_ff   <= rd_last_in;
      val_ff       <= val_in;
      rsp_ff       <= rsp_in;
   end

endmodule
`default_nettype wire
